// File: sv/gwh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gwh_pkg;

    localparam int CoordW        = 16;
    localparam int MaxPointsDef  = 64;
    localparam int DiffW         = CoordW + 1;
    localparam int ProdW         = 2 * DiffW;
    localparam int SumW          = ProdW + 1;

    typedef logic signed [CoordW-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
        logic   valid;
    } t_pt;

    typedef struct packed {
        logic shift;
        logic clr;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_MINY,
        ST_INIT,
        ST_CHECK,
        ST_WALK,
        ST_DECIDE,
        ST_EMIT,
        ST_FINAL
    } t_state;

endpackage

`default_nettype wire

// File: sv/gwh_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module gwh_cell (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire gwh_pkg::t_cell_ctl  i_ctl,
    input  wire gwh_pkg::t_pt        i_pt,
    output gwh_pkg::t_pt             o_pt
);

    gwh_pkg::t_coord r_x;
    gwh_pkg::t_coord r_y;
    logic            r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_valid <= 1'b0;
        end else if (i_ctl.shift) begin
            r_valid <= i_pt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_x <= i_pt.x;
            r_y <= i_pt.y;
        end
    end

    assign o_pt = '{x: r_x, y: r_y, valid: r_valid};

endmodule

`default_nettype wire

// File: sv/gwh_eval.sv
`timescale 1ns / 1ps
`default_nettype none

// three register stages: differences, products, cross and squared distances
module gwh_eval (
    input  wire logic             i_clk,
    input  wire gwh_pkg::t_coord  i_px,
    input  wire gwh_pkg::t_coord  i_py,
    input  wire gwh_pkg::t_coord  i_qx,
    input  wire gwh_pkg::t_coord  i_qy,
    input  wire gwh_pkg::t_coord  i_rx,
    input  wire gwh_pkg::t_coord  i_ry,
    output logic                  o_take
);

    localparam int DW = gwh_pkg::DiffW;
    localparam int PW = gwh_pkg::ProdW;
    localparam int SW = gwh_pkg::SumW;

    logic signed [DW-1:0] r_qpx, r_qpy, r_rpx, r_rpy, r_qrx, r_qry;
    logic signed [PW-1:0] r_m1, r_m2, r_m3, r_m4, r_m5, r_m6;
    logic signed [SW-1:0] r_cross, r_dr, r_dp;

    always_ff @(posedge i_clk) begin
        r_qpx <= DW'(i_qx) - DW'(i_px);
        r_qpy <= DW'(i_qy) - DW'(i_py);
        r_rpx <= DW'(i_rx) - DW'(i_px);
        r_rpy <= DW'(i_ry) - DW'(i_py);
        r_qrx <= DW'(i_qx) - DW'(i_rx);
        r_qry <= DW'(i_qy) - DW'(i_ry);
    end

    always_ff @(posedge i_clk) begin
        r_m1 <= PW'(r_qpx) * PW'(r_rpy);
        r_m2 <= PW'(r_qpy) * PW'(r_rpx);
        r_m3 <= PW'(r_qrx) * PW'(r_qrx);
        r_m4 <= PW'(r_qry) * PW'(r_qry);
        r_m5 <= PW'(r_qpx) * PW'(r_qpx);
        r_m6 <= PW'(r_qpy) * PW'(r_qpy);
    end

    always_ff @(posedge i_clk) begin
        r_cross <= SW'(r_m1) - SW'(r_m2);
        r_dr    <= SW'(r_m3) + SW'(r_m4);
        r_dp    <= SW'(r_m5) + SW'(r_m6);
    end

    assign o_take = (r_cross > 0) || ((r_cross == 0) && (r_dr >= r_dp));

endmodule

`default_nettype wire

// File: sv/convex_hull_gift_wrap.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  handshake         payload
// s_axis   in   tvalid / tready   tdata = point_x, point_y; tlast = last_point
// m_axis   out  tvalid / tready   tdata = hull_x, hull_y;   tlast = last_vertex
//
// Points shift into a chain of MAX_POINTS cells, one per cycle, no stall.
// On tlast: a min-y pass over all MAX_POINTS cells, then per hull vertex one
// rotation of the chain, each shift waiting out the evaluator depth + decision.
// tready is low from tlast until the final vertex is loaded for output.
// Synchronous active-low reset empties the chain; m_axis stalls hold the walk.
module convex_hull_gift_wrap #(
    parameter int MAX_POINTS = gwh_pkg::MaxPointsDef
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,  // [15:0] point_x, [31:16] point_y
    input  wire logic        i_s_axis_tlast,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata,  // [15:0] hull_x, [31:16] hull_y
    output logic             o_m_axis_tlast
);

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam logic [IW-1:0] IdxLast = IW'(MAX_POINTS - 1);
    localparam logic [CW-1:0] CntMax  = CW'(MAX_POINTS);

    gwh_pkg::t_state    r_state, n_state;
    gwh_pkg::t_cell_ctl w_ctl;
    gwh_pkg::t_pt       w_cell [MAX_POINTS];
    gwh_pkg::t_pt       w_in   [MAX_POINTS];
    gwh_pkg::t_pt       w_tail;
    gwh_pkg::t_pt       w_head;

    logic [CW-1:0] r_count;
    logic [CW-1:0] r_nvert;
    logic [IW-1:0] r_idx;
    logic [1:0]    r_ph;
    logic          r_have;
    gwh_pkg::t_coord r_bx, r_by, r_sx, r_sy, r_px, r_py, r_cx, r_cy;
    gwh_pkg::t_coord r_kx, r_ky, r_ex, r_ey;
    logic          r_ovalid, r_olast;
    gwh_pkg::t_coord r_ox, r_oy;

    logic w_s_acc, w_ofree, w_take, w_step, w_scan_end, w_cand_ok;

    assign w_s_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign w_ofree = !r_ovalid || i_m_axis_tready;
    assign w_head  = w_cell[0];
    assign w_scan_end = w_step && (r_idx == IdxLast);

    always_comb begin
        w_tail = w_head;
        if (r_state == gwh_pkg::ST_LOAD) begin
            w_tail = '{x: gwh_pkg::t_coord'(i_s_axis_tdata[15:0]),
                       y: gwh_pkg::t_coord'(i_s_axis_tdata[31:16]), valid: 1'b1};
        end
    end

    for (genvar i = 0; i < MAX_POINTS; i++) begin : g_chain
        if (i == MAX_POINTS - 1) begin : g_tail
            assign w_in[i] = w_tail;
        end else begin : g_mid
            assign w_in[i] = w_cell[i+1];
        end
        gwh_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_pt    (w_in[i]),
            .o_pt    (w_cell[i])
        );
    end

    gwh_eval u_eval (
        .i_clk  (i_clk),
        .i_px   (r_kx),
        .i_py   (r_ky),
        .i_qx   (r_cx),
        .i_qy   (r_cy),
        .i_rx   (w_head.x),
        .i_ry   (w_head.y),
        .o_take (w_take)
    );

    assign w_cand_ok = w_head.valid && w_take
                    && !((w_head.x == r_px) && (w_head.y == r_py))
                    && !((w_head.x == r_cx) && (w_head.y == r_cy));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gwh_pkg::ST_LOAD:   if (w_s_acc && i_s_axis_tlast) n_state = gwh_pkg::ST_MINY;
            gwh_pkg::ST_MINY:   if (w_scan_end) n_state = gwh_pkg::ST_INIT;
            gwh_pkg::ST_INIT:   n_state = gwh_pkg::ST_CHECK;
            gwh_pkg::ST_CHECK:  n_state = (r_nvert == CntMax) ? gwh_pkg::ST_FINAL
                                                              : gwh_pkg::ST_WALK;
            gwh_pkg::ST_WALK:   if (w_scan_end) n_state = gwh_pkg::ST_DECIDE;
            gwh_pkg::ST_DECIDE: n_state = ((r_kx == r_sx) && (r_ky == r_sy))
                                          ? gwh_pkg::ST_FINAL : gwh_pkg::ST_EMIT;
            gwh_pkg::ST_EMIT:   if (w_ofree) n_state = gwh_pkg::ST_CHECK;
            gwh_pkg::ST_FINAL:  if (w_ofree) n_state = gwh_pkg::ST_LOAD;
            default:            n_state = gwh_pkg::ST_LOAD;
        endcase
    end

    always_comb begin
        o_s_axis_tready = 1'b0;
        w_step          = 1'b0;
        w_ctl           = '0;
        unique case (r_state)
            gwh_pkg::ST_LOAD: begin
                o_s_axis_tready = 1'b1;
                w_ctl.shift     = w_s_acc && (r_count != CntMax);
            end
            gwh_pkg::ST_MINY: begin
                w_step      = 1'b1;
                w_ctl.shift = 1'b1;
            end
            gwh_pkg::ST_WALK: begin
                w_step      = (r_ph == 2'd3);
                w_ctl.shift = (r_ph == 2'd3);
            end
            gwh_pkg::ST_FINAL: begin
                w_ctl.clr = w_ofree;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= gwh_pkg::ST_LOAD;
            r_count  <= '0;
            r_idx    <= '0;
            r_ph     <= '0;
            r_have   <= 1'b0;
            r_nvert  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_ovalid && i_m_axis_tready) r_ovalid <= 1'b0;
            if (w_ctl.shift && r_state == gwh_pkg::ST_LOAD) r_count <= r_count + 1'b1;
            if (r_state == gwh_pkg::ST_WALK) r_ph <= r_ph + 2'd1;
            else r_ph <= '0;
            if (w_step) r_idx <= w_scan_end ? '0 : r_idx + 1'b1;
            if (r_state == gwh_pkg::ST_MINY && w_head.valid) r_have <= 1'b1;
            if (r_state == gwh_pkg::ST_INIT) begin
                r_have  <= 1'b0;
                r_nvert <= CW'(1);
            end
            if (r_state == gwh_pkg::ST_EMIT && w_ofree) begin
                r_ovalid <= 1'b1;
                r_nvert  <= r_nvert + 1'b1;
            end
            if (r_state == gwh_pkg::ST_FINAL && w_ofree) begin
                r_ovalid <= 1'b1;
                r_count  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == gwh_pkg::ST_MINY && w_head.valid && (!r_have || w_head.y < r_by)) begin
            r_bx <= w_head.x;
            r_by <= w_head.y;
        end
        unique case (r_state)
            gwh_pkg::ST_INIT: begin
                r_sx <= r_bx; r_sy <= r_by;
                r_px <= r_bx; r_py <= r_by;
                r_cx <= r_bx; r_cy <= r_by;
                r_ex <= r_bx; r_ey <= r_by;
            end
            gwh_pkg::ST_CHECK: begin
                r_kx <= r_px; r_ky <= r_py;
            end
            gwh_pkg::ST_WALK: begin
                if (w_step && w_cand_ok) begin
                    r_kx <= w_head.x;
                    r_ky <= w_head.y;
                end
            end
            gwh_pkg::ST_EMIT: begin
                if (w_ofree) begin
                    r_ox <= r_ex; r_oy <= r_ey; r_olast <= 1'b0;
                    r_ex <= r_kx; r_ey <= r_ky;
                    r_px <= r_cx; r_py <= r_cy;
                    r_cx <= r_kx; r_cy <= r_ky;
                end
            end
            gwh_pkg::ST_FINAL: begin
                if (w_ofree) begin
                    r_ox <= r_ex; r_oy <= r_ey; r_olast <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {r_oy, r_ox};
    assign o_m_axis_tlast  = r_olast;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntMax)
        else $error("point count beyond store depth");
    a_nvert_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nvert <= CntMax)
        else $error("vertex count beyond bound");
    a_ready_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> (r_state == gwh_pkg::ST_LOAD))
        else $error("input taken outside load");
    a_final_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gwh_pkg::ST_FINAL && w_ofree) |=> (r_count == '0))
        else $error("store not emptied after final vertex");
    a_walk_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gwh_pkg::ST_WALK && w_ctl.shift) |-> (r_ph == 2'd3))
        else $error("chain shifted before evaluator settled");

endmodule

`default_nettype wire

// File: tb/tb_convex_hull_gift_wrap.sv
`timescale 1ns / 1ps

module tb_convex_hull_gift_wrap;

    localparam int NPTS       = gwh_pkg::MaxPointsDef;
    localparam int STALL_MAX  = 60000;
    localparam int HOLD_LONG  = 3000;

    typedef struct {
        gwh_pkg::t_coord x;
        gwh_pkg::t_coord y;
        logic            last;
    } t_vertex;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic [31:0] i_s_axis_tdata = '0;
    logic        i_s_axis_tlast = 1'b0;
    logic        i_m_axis_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [31:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;

    convex_hull_gift_wrap dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    longint  pts_x [NPTS];
    longint  pts_y [NPTS];
    int      pts_n = 0;
    t_vertex hull_q [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req = 0;
    int hold_left = 0;
    int mismatches = 0;
    int vertices_seen = 0;
    int points_sent = 0;
    int sets_sent = 0;
    int idle_cycles = 0;

    function automatic bit same_point(int a, int b);
        return pts_x[a] == pts_x[b] && pts_y[a] == pts_y[b];
    endfunction

    function automatic longint dist_sq(int a, int b);
        longint dx, dy;
        dx = pts_x[a] - pts_x[b];
        dy = pts_y[a] - pts_y[b];
        return dx * dx + dy * dy;
    endfunction

    function automatic bit better_candidate(int p, int q, int r);
        longint cr;
        cr = (pts_x[q] - pts_x[p]) * (pts_y[r] - pts_y[p])
           - (pts_y[q] - pts_y[p]) * (pts_x[r] - pts_x[p]);
        if (cr != 0) return cr > 0;
        return dist_sq(q, r) >= dist_sq(q, p);
    endfunction

    task automatic push_vertex(int idx, bit last);
        t_vertex v;
        v.x = gwh_pkg::t_coord'(pts_x[idx]);
        v.y = gwh_pkg::t_coord'(pts_y[idx]);
        v.last = last;
        hull_q = {hull_q, v};
    endtask

    // gift wrap over the stored set, expected vertices appended in walk order
    task automatic predict_hull();
        int start, prev, cur, cand, emitted;
        start = 0;
        for (int i = 1; i < pts_n; i++)
            if (pts_y[i] < pts_y[start]) start = i;
        push_vertex(start, 1'b0);
        emitted = 1;
        prev = start;
        cur = start;
        while (emitted < NPTS) begin
            cand = prev;
            for (int i = 0; i < pts_n; i++)
                if (!same_point(i, prev) && !same_point(i, cur) &&
                    better_candidate(cand, cur, i))
                    cand = i;
            if (same_point(cand, start)) break;
            push_vertex(cand, 1'b0);
            emitted++;
            prev = cur;
            cur = cand;
        end
        hull_q[$].last = 1'b1;
        pts_n = 0;
    endtask

    task automatic accept_point(gwh_pkg::t_coord x, gwh_pkg::t_coord y, bit last);
        if (pts_n < NPTS) begin
            pts_x[pts_n] = x;
            pts_y[pts_n] = y;
            pts_n++;
        end
        if (last) predict_hull();
    endtask

    // entered and left just after a rising edge
    task automatic send_point(gwh_pkg::t_coord x, gwh_pkg::t_coord y, bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {y, x};
        i_s_axis_tlast  <= last;
        do @(negedge i_clk); while (!o_s_axis_tready);
        accept_point(x, y, last);
        points_sent++;
        if (last) sets_sent++;
        @(posedge i_clk);
    endtask

    task automatic stop_sending();
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tlast  <= 1'b0;
    endtask

    task automatic drain();
        stop_sending();
        while (hull_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    function automatic gwh_pkg::t_coord rand_coord(bit wide);
        if (wide) return gwh_pkg::t_coord'($urandom());
        return gwh_pkg::t_coord'($urandom_range(8) - 4);
    endfunction

    task automatic send_random_set(int n);
        bit wide;
        wide = $urandom_range(1);
        for (int i = 0; i < n; i++)
            send_point(rand_coord(wide), rand_coord(wide), i == n - 1);
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // sampled mid-cycle: the values the next rising edge will see
    always @(negedge i_clk) begin
        t_vertex w;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            vertices_seen++;
            if (hull_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected vertex x=%0d y=%0d last=%0b",
                             $signed(o_m_axis_tdata[15:0]),
                             $signed(o_m_axis_tdata[31:16]), o_m_axis_tlast);
            end else begin
                w = hull_q.pop_front();
                if (o_m_axis_tdata[15:0] !== w.x || o_m_axis_tdata[31:16] !== w.y ||
                    o_m_axis_tlast !== w.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("vertex mismatch: exp x=%0d y=%0d last=%0b, %s",
                                 w.x, w.y, w.last, "got:");
                    if (mismatches <= 10)
                        $display("    x=%0d y=%0d last=%0b",
                                 $signed(o_m_axis_tdata[15:0]),
                                 $signed(o_m_axis_tdata[31:16]), o_m_axis_tlast);
                end
            end
        end
        if ((o_m_axis_tvalid && i_m_axis_tready) || (i_s_axis_tvalid && o_s_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_MAX) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic test_directed();
        gwh_pkg::t_coord mn, mx;
        mn = -32768;
        mx = 32767;
        send_point(5, -7, 1'b1);                          // single point
        for (int i = 0; i < 4; i++) send_point(3, 3, i == 3);  // all equal
        for (int i = 0; i < 5; i++)
            send_point(gwh_pkg::t_coord'(i), gwh_pkg::t_coord'(2 * i), i == 4);
        send_point(mx, mx, 1'b0);                         // extreme corners
        send_point(mn, mx, 1'b0);
        send_point(mn, mn, 1'b0);
        send_point(mx, mn, 1'b0);
        send_point(0, 0, 1'b0);
        send_point(mn, mn, 1'b1);
        send_point(0, 0, 1'b0);                           // square with midpoints on its bottom and left edges
        send_point(2, 0, 1'b0);
        send_point(1, 0, 1'b0);
        send_point(2, 2, 1'b0);
        send_point(0, 2, 1'b0);
        send_point(0, 1, 1'b1);
        drain();
    endtask

    // 64 convex points fill the store and bound the walk; extra points dropped
    task automatic test_store_full();
        for (int i = -32; i < 32; i++)
            send_point(gwh_pkg::t_coord'(i), gwh_pkg::t_coord'(i * i), 1'b0);
        send_point(-100, -5000, 1'b0);
        send_point(100, -5000, 1'b1);
        drain();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        @(negedge i_clk);
        hold_req = HOLD_LONG;
        @(posedge i_clk);
        send_random_set(6);
        send_random_set(5);
        drain();
    endtask

    task automatic test_random(int idle, int stall, int n_points);
        int left, n;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        left = n_points;
        while (left > 0) begin
            n = $urandom_range(12, 1);
            if (n > left) n = left;
            send_random_set(n);
            left -= n;
        end
        drain();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_store_full();
        test_random(0, 0, 6);
        test_random(78, 0, 6);
        test_random(0, 78, 6);
        test_random(19, 19, 6);
        test_backpressure();
        $display("Covered %0d points in %0d sets, %0d hull vertices checked,",
                 points_sent, sets_sent, vertices_seen);
        $display("including degenerate sets, a full store and a long output hold-off.");
        if (mismatches == 0 && hull_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
